// File: src/svpd_pkg.sv
// shared types, constants and coil pattern table for the valve stepper drive
// no dependencies; imported by svpd_cfg_regs, svpd_motion and the top level
package svpd_pkg;

    localparam int POSITION_BITS = 16;
    localparam int OVERSHOOT_BITS = 8;
    localparam int COUNT_BITS = 16;
    localparam int CFG_WORD_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OVERSHOOT_BITS-1:0] overshoot_t;
    typedef logic [2:0] phase_t;
    typedef logic [3:0] coil_t;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        REG_ENABLED        = 3'd0,
        REG_NORMAL_OPEN    = 3'd1,
        REG_OVERRUN_LIMIT  = 3'd2,
        REG_ORIGIN_MARGIN  = 3'd3,
        REG_ZERO_APPROACH  = 3'd4
    } reg_index_t;

    localparam logic [15:0] ENABLED_RESET        = 16'd1;
    localparam logic [15:0] OVERRUN_LIMIT_RESET  = 16'd300;
    localparam logic [15:0] ORIGIN_MARGIN_RESET  = 16'd40;
    localparam logic [15:0] ZERO_APPROACH_RESET  = 16'd780;
    localparam count_t OVERRUN_MAX_RESET         = count_t'(300);

    typedef struct packed
    {
        logic        enabled;
        logic        normal_open;
        logic [15:0] overrun_limit;
        logic [15:0] origin_margin;
        logic [15:0] zero_approach;
    } cfg_t;

    typedef struct packed
    {
        logic        operation;
        logic [15:0] target_position;
        logic [7:0]  open_overshoot;
        logic        origin_sensor;
    } cmd_t;

    typedef struct packed
    {
        logic [3:0]  coils;
        logic        running;
        logic [15:0] position;
    } rsp_t;

    // half-step pattern: bit3 X1, bit2 X2, bit1 Y1, bit0 Y2
    function automatic coil_t coil_pattern(input phase_t phase);
        coil_t pattern;
        begin
            case (phase)
                3'd0:    pattern = 4'hA;
                3'd1:    pattern = 4'h2;
                3'd2:    pattern = 4'h6;
                3'd3:    pattern = 4'h4;
                3'd4:    pattern = 4'h5;
                3'd5:    pattern = 4'h1;
                3'd6:    pattern = 4'h9;
                default: pattern = 4'h8;
            endcase
            return pattern;
        end
    endfunction

endpackage

// File: src/svpd_cmd_if.sv
// command channel: valid/ready handshake carrying one input item
// depends on nothing
interface svpd_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] target_position;
    logic [7:0]  open_overshoot;
    logic        origin_sensor;

    modport source (output valid, output operation, output target_position,
                    output open_overshoot, output origin_sensor, input ready);
    modport sink (input valid, input operation, input target_position,
                  input open_overshoot, input origin_sensor, output ready);
endinterface

// File: src/svpd_rsp_if.sv
// result channel: valid/ready handshake carrying one result item
// depends on nothing
interface svpd_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  coils;
    logic        running;
    logic [15:0] position;

    modport source (output valid, output coils, output running, output position,
                    input ready);
    modport sink (input valid, input coils, input running, input position,
                  output ready);
endinterface

// File: src/svpd_cfg_regs.sv
// configuration register file of the valve stepper drive, write only
// depends on svpd_pkg
module svpd_cfg_regs
    import svpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_WORD_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ENABLED:        cfg_next.enabled = cfg_data[0];
                REG_NORMAL_OPEN:    cfg_next.normal_open = cfg_data[0];
                REG_OVERRUN_LIMIT:  cfg_next.overrun_limit = cfg_data[15:0];
                REG_ORIGIN_MARGIN:  cfg_next.origin_margin = cfg_data[15:0];
                REG_ZERO_APPROACH:  cfg_next.zero_approach = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled        <= ENABLED_RESET[0];
            cfg_reg.normal_open    <= 1'b0;
            cfg_reg.overrun_limit  <= OVERRUN_LIMIT_RESET;
            cfg_reg.origin_margin  <= ORIGIN_MARGIN_RESET;
            cfg_reg.zero_approach  <= ZERO_APPROACH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/svpd_motion.sv
// motion state of the drive and its single-pass update for one item
// depends on svpd_pkg
module svpd_motion
    import svpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic fire,
    input  cmd_t cmd,
    output rsp_t rsp
);

    logic       run_reg, run_next;
    pos_t       cur_reg, cur_next;
    pos_t       tgt_reg, tgt_next;
    count_t     cnt_reg, cnt_next;
    overshoot_t pend_reg, pend_next;
    phase_t     phase_reg, phase_next;
    pos_t       osp_reg, osp_next;
    logic       osf_reg, osf_next;
    count_t     com_reg, com_next;
    coil_t      coil_reg, coil_next;

    pos_t   tpos;
    pos_t   cur_inc;
    pos_t   cur_dec;
    phase_t phase_up;
    phase_t phase_down;
    pos_t   lim_raw;
    count_t lim_cap;

    assign tpos       = pos_t'(cmd.target_position);
    assign cur_inc    = cur_reg + pos_t'(1);
    assign cur_dec    = cur_reg - pos_t'(1);
    assign phase_up   = phase_reg + (cfg.normal_open ? 3'd7 : 3'd1);
    assign phase_down = phase_reg + (cfg.normal_open ? 3'd1 : 3'd7);
    assign lim_raw    = osp_reg - pos_t'(cfg.origin_margin);
    assign lim_cap    = (count_t'(lim_raw) > count_t'(cfg.overrun_limit)) ?
                        count_t'(cfg.overrun_limit) : count_t'(lim_raw);

    always_comb
    begin
        run_next   = run_reg;
        cur_next   = cur_reg;
        tgt_next   = tgt_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        phase_next = phase_reg;
        osp_next   = osp_reg;
        osf_next   = osf_reg;
        com_next   = com_reg;
        coil_next  = coil_reg;

        case (op_t'(cmd.operation))
            OP_START:
            begin
                if (!run_reg && cur_reg != tpos)
                begin
                    run_next = 1'b1;
                    if (tpos == '0)
                    begin
                        // homing: push position up by the approach distance
                        cur_next = cur_reg + pos_t'(cfg.zero_approach);
                        cnt_next = '0;
                        tgt_next = '0;
                    end
                    else if (cur_reg >= tpos)
                    begin
                        cnt_next  = '0;
                        pend_next = '0;
                        tgt_next  = tpos;
                    end
                    else
                    begin
                        pend_next = cmd.open_overshoot;
                        tgt_next  = tpos + pos_t'(cmd.open_overshoot);
                    end
                end
            end
            default:
            begin
                if (cfg.enabled)
                begin
                    if (!run_reg)
                    begin
                        coil_next = '0;
                    end
                    else if (tgt_reg > cur_reg)
                    begin
                        // opening step, tracks the origin sensor
                        cur_next   = cur_inc;
                        phase_next = phase_up;
                        coil_next  = coil_pattern(phase_up);
                        if (cmd.origin_sensor)
                        begin
                            osp_next = cur_inc;
                            osf_next = 1'b1;
                        end
                        else if (osf_reg)
                        begin
                            com_next = lim_cap;
                        end
                    end
                    else if (tgt_reg < cur_reg)
                    begin
                        if (cmd.origin_sensor && cnt_reg >= com_reg)
                        begin
                            // overrun done on the sensor: home reached
                            tgt_next  = '0;
                            cur_next  = '0;
                            cnt_next  = '0;
                            run_next  = 1'b0;
                            coil_next = '0;
                        end
                        else
                        begin
                            if (cmd.origin_sensor)
                            begin
                                cnt_next = cnt_reg + count_t'(1);
                            end
                            cur_next   = cur_dec;
                            phase_next = phase_down;
                            if (cur_dec == '0)
                            begin
                                cnt_next  = '0;
                                tgt_next  = '0;
                                run_next  = 1'b0;
                                coil_next = '0;
                            end
                            else
                            begin
                                coil_next = coil_pattern(phase_down);
                            end
                        end
                    end
                    else if (tgt_reg != '0 && pend_reg != '0)
                    begin
                        // overshoot reached: turn back to the real target
                        tgt_next  = tgt_reg - pos_t'(pend_reg);
                        pend_next = '0;
                    end
                    else
                    begin
                        cnt_next  = '0;
                        run_next  = 1'b0;
                        coil_next = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            cur_reg   <= '0;
            tgt_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= '0;
            phase_reg <= '0;
            osp_reg   <= '0;
            osf_reg   <= 1'b0;
            com_reg   <= OVERRUN_MAX_RESET;
            coil_reg  <= '0;
        end
        else if (fire)
        begin
            run_reg   <= run_next;
            cur_reg   <= cur_next;
            tgt_reg   <= tgt_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
            osp_reg   <= osp_next;
            osf_reg   <= osf_next;
            com_reg   <= com_next;
            coil_reg  <= coil_next;
        end
    end

    assign rsp.coils    = cfg.enabled ? coil_next : 4'h0;
    assign rsp.running  = run_next;
    assign rsp.position = 16'(cur_next);

endmodule

// File: src/stepper_valve_position_drive_core.sv
// top level of the valve stepper drive: input register, motion update, result register
// depends on svpd_pkg, svpd_cmd_if, svpd_rsp_if, svpd_cfg_regs, svpd_motion

// Half-step valve stepper drive. Each command item is either a start (sets a
// target; target 0 homes the valve onto the hall origin sensor) or a tick (one
// motor pulse toward the target). Every item yields exactly one result item
// with the coil pattern, the running flag and the current position. The block
// takes one item per clock cycle while its results are taken. An accepted item
// passes through the input register and then the result register, which
// offers its result; the state update in between is a single pass of
// compares and 16-bit increments. A result that is not taken holds the next
// item in the input register, and the input stalls only while both are full.
// Configuration registers are written through a plain write port and should
// only change while no item is in flight.
module stepper_valve_position_drive_core
    import svpd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    svpd_cmd_if.sink                  cmd,
    svpd_rsp_if.source                rsp,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_WORD_BITS-1:0]  cfg_data
);

    cfg_t cfg;

    // input register stage
    logic cmd_valid_reg;
    cmd_t cmd_item_reg;

    // result register stage
    logic rsp_valid_reg;
    rsp_t rsp_item_reg;
    rsp_t rsp_item_next;

    logic fire;

    svpd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the item in the input register is processed when the result slot is free
    // or being emptied in this same cycle
    assign fire      = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_item_reg.operation       <= cmd.operation;
            cmd_item_reg.target_position <= cmd.target_position;
            cmd_item_reg.open_overshoot  <= cmd.open_overshoot;
            cmd_item_reg.origin_sensor   <= cmd.origin_sensor;
        end
    end

    // motion state lives here; it commits on fire
    svpd_motion u_motion
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .fire  (fire),
        .cmd   (cmd_item_reg),
        .rsp   (rsp_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.coils    = rsp_item_reg.coils;
    assign rsp.running  = rsp_item_reg.running;
    assign rsp.position = rsp_item_reg.position;

endmodule
